// File: rtl/wsfe_pkg.sv
package wsfe_pkg;

	// field widths
	localparam int unsigned OPC_W  = 4;
	localparam int unsigned LEN_W  = 64;
	localparam int unsigned KEY_W  = 32;
	localparam int unsigned BYTE_W = 8;

	// header buffer: up to 2 + 8 + 4 bytes
	localparam int unsigned HDR_BYTES_MAX = 14;
	localparam int unsigned HDR_W         = HDR_BYTES_MAX * BYTE_W;
	localparam int unsigned CNT_W         = 4;

	// packed input data: opcode, length, key, byte, padded to whole bytes
	localparam int unsigned S_DATA_W = 112;
	localparam int unsigned OPC_LSB  = 0;
	localparam int unsigned LEN_LSB  = OPC_LSB + OPC_W;
	localparam int unsigned KEY_LSB  = LEN_LSB + LEN_W;
	localparam int unsigned DATA_LSB = KEY_LSB + KEY_W;

	// request kinds
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	// header constants
	localparam logic [BYTE_W-1:0] FIN_BIT       = 8'h80;
	localparam logic [LEN_W-1:0]  LEN7_LIMIT    = 64'd126;
	localparam logic [6:0]        LEN16_CODE    = 7'h7E;
	localparam logic [6:0]        LEN64_CODE    = 7'h7F;

	// header byte counts
	localparam logic [CNT_W-1:0] HDR_N_LEN7  = 4'd2;
	localparam logic [CNT_W-1:0] HDR_N_LEN16 = 4'd4;
	localparam logic [CNT_W-1:0] HDR_N_LEN64 = 4'd10;
	localparam logic [CNT_W-1:0] HDR_N_KEY   = 4'd4;

	// one byte on the wire with its flags
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              is_header;
		logic              run_last;
		logic              frame_last;
		logic              overrun;
	} res_t;

	// built header: bytes in wire order from the low end, and their count
	typedef struct packed {
		logic [HDR_W-1:0] bytes;
		logic [CNT_W-1:0] cnt;
	} hdr_t;

	function automatic hdr_t hdr_build(
		input logic [OPC_W-1:0] opc,
		input logic [LEN_W-1:0] len,
		input logic [KEY_W-1:0] key,
		input logic             men
	);
		hdr_t              h;
		logic [KEY_W-1:0]  kbe;
		h.bytes = '0;
		// key with its most significant byte sent first
		kbe = {key[7:0], key[15:8], key[23:16], key[31:24]};
		h.bytes[7:0] = FIN_BIT | {4'b0000, opc};
		if (len < LEN7_LIMIT) begin
			h.bytes[15:8] = {men, len[6:0]};
			h.cnt = HDR_N_LEN7;
			if (men) begin
				h.bytes[47:16] = kbe;
			end
		end else if (len[LEN_W-1:16] == '0) begin
			h.bytes[15:8]  = {men, LEN16_CODE};
			h.bytes[23:16] = len[15:8];
			h.bytes[31:24] = len[7:0];
			h.cnt = HDR_N_LEN16;
			if (men) begin
				h.bytes[63:32] = kbe;
			end
		end else begin
			h.bytes[15:8] = {men, LEN64_CODE};
			for (int i = 0; i < 8; i++) begin
				h.bytes[16 + 8*i +: 8] = len[LEN_W-1 - 8*i -: 8];
			end
			h.cnt = HDR_N_LEN64;
			if (men) begin
				h.bytes[111:80] = kbe;
			end
		end
		if (men) begin
			h.cnt = h.cnt + HDR_N_KEY;
		end
		return h;
	endfunction

endpackage

// File: rtl/wsfe_ingest.sv
module wsfe_ingest
	import wsfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [OPC_W-1:0]  opcode,
	input  logic [LEN_W-1:0]  payload_length,
	input  logic [KEY_W-1:0]  mask_key,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              job_valid,
	output res_t              job_res,
	input  logic              job_take
);

	// configuration and frame state
	logic              mask_en_q;
	logic [KEY_W-1:0]  key_q;
	logic [1:0]        phase_q;
	logic [LEN_W-1:0]  rem_q;
	logic              mact_q;

	// job register: bytes still to send for the current item
	logic              job_valid_q;
	logic [HDR_W-1:0]  buf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              hdr_q;
	logic              fin_q;
	logic              ov_q;

	logic              accept;
	logic              job_done;
	hdr_t              hdr;
	logic [BYTE_W-1:0] key_byte;
	logic [BYTE_W-1:0] pay_byte;
	logic              rem_zero;

	assign job_done = job_valid_q && job_take && (cnt_q == 4'd1);
	assign in_ready = !job_valid_q || job_done;
	assign accept   = in_valid && in_ready;

	// header bytes and masked payload byte
	always_comb begin
		hdr      = hdr_build(opcode, payload_length, mask_key, mask_en_q);
		rem_zero = (rem_q == '0);
		case (phase_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		pay_byte = (mact_q && !rem_zero) ? (data_byte ^ key_byte) : data_byte;
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_en_q <= 1'b0;
		end else if (cfg_we) begin
			mask_en_q <= cfg_data;
		end
	end

	// frame state update on accepted items; an overrun byte leaves it as is
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			phase_q <= '0;
			rem_q   <= '0;
			mact_q  <= 1'b0;
		end else if (accept) begin
			if (req_type == REQ_START) begin
				key_q   <= mask_key;
				phase_q <= '0;
				rem_q   <= payload_length;
				mact_q  <= mask_en_q;
			end else if (!rem_zero) begin
				phase_q <= phase_q + 2'd1;
				rem_q   <= rem_q - 64'd1;
			end
		end
	end

	// job register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (accept) begin
			job_valid_q <= 1'b1;
			cnt_q       <= (req_type == REQ_START) ? hdr.cnt : 4'd1;
		end else if (job_valid_q && job_take) begin
			job_valid_q <= (cnt_q != 4'd1);
			cnt_q       <= cnt_q - 4'd1;
		end
	end

	// job payload: load on accept, shift one byte per transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_type == REQ_START) begin
				buf_q <= hdr.bytes;
				hdr_q <= 1'b1;
				fin_q <= (payload_length == '0);
				ov_q  <= 1'b0;
			end else begin
				buf_q <= {{(HDR_W-BYTE_W){1'b0}}, pay_byte};
				hdr_q <= 1'b0;
				fin_q <= (rem_q == 64'd1);
				ov_q  <= rem_zero;
			end
		end else if (job_valid_q && job_take) begin
			buf_q <= {{BYTE_W{1'b0}}, buf_q[HDR_W-1:BYTE_W]};
		end
	end

	assign job_valid           = job_valid_q;
	assign job_res.out_byte    = buf_q[BYTE_W-1:0];
	assign job_res.is_header   = hdr_q;
	assign job_res.run_last    = (cnt_q == 4'd1);
	assign job_res.frame_last  = fin_q && (cnt_q == 4'd1);
	assign job_res.overrun     = ov_q;

	// a pending job always has bytes left
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> (cnt_q != '0))
		else $error("job pending with zero byte count");

	// a payload job is exactly one byte
	a_payload_single: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid_q && !hdr_q) |-> (cnt_q == 4'd1))
		else $error("payload job longer than one byte");

	// an overrun byte is never header and never ends a frame
	a_overrun_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid_q && ov_q) |-> (!hdr_q && !fin_q))
		else $error("overrun byte with header or frame end flag");

	// a new item is taken only once the previous job is on its last byte
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && job_valid_q) |-> (job_take && (cnt_q == 4'd1)))
		else $error("job overwritten before drained");

endmodule

// File: rtl/wsfe_outreg.sv
module wsfe_outreg
	import wsfe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_take,
	input  res_t in_res,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic valid_q;
	res_t res_q;
	logic load;

	// output register refills when empty or when its byte is taken
	assign load    = !valid_q || out_ready;
	assign in_take = in_valid && load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			res_q <= in_res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

	// a byte moves in only when the register is free or being drained
	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |-> (!valid_q || out_ready))
		else $error("output register overwritten while stalled");

	// a stalled byte stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> (valid_q && $stable(res_q)))
		else $error("stalled output byte changed");

	// a ready source always lands when the register can take it
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !valid_q) |=> valid_q)
		else $error("output register skipped a pending byte");

endmodule

// File: rtl/websocket_frame_encoder_top.sv
// WebSocket frame sender. A start item (tuser 0) emits the frame header one
// byte per transfer: 0x80 plus the opcode, the length byte (7-bit, 126 with a
// 16-bit field, or 127 with a 64-bit field, all big-endian) and, when
// mask_enable was set at the start, the 4 key bytes with the mask bit raised.
// A payload item (tuser 1) emits one byte, XORed with the key byte for its
// position modulo 4; a byte beyond the declared length passes unmasked with
// the overrun flag. A payload item emits one byte; a start item emits 2, 4,
// 6, 8, 10 or 14 bytes by length form and masking, through the single-byte
// output register. The next item is taken in the cycle that the last byte
// of the previous one moves into the output register, so payload streams at
// one byte per clock while neither side stalls.
module websocket_frame_encoder_top
	import wsfe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_data,        // mask_enable
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,    // opcode, payload_length, mask_key, data_byte
	input  logic                s_axis_tuser,    // req_type
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [BYTE_W-1:0]   m_axis_tdata,    // out_byte
	output logic [2:0]          m_axis_tuser,    // is_header, run_last, overrun
	output logic                m_axis_tlast     // frame_last
);

	logic job_valid;
	logic job_take;
	res_t job_res;
	res_t out_res;

	// frame state and per-item byte buffer
	wsfe_ingest u_ingest (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.req_type       (s_axis_tuser),
		.opcode         (s_axis_tdata[OPC_LSB +: OPC_W]),
		.payload_length (s_axis_tdata[LEN_LSB +: LEN_W]),
		.mask_key       (s_axis_tdata[KEY_LSB +: KEY_W]),
		.data_byte      (s_axis_tdata[DATA_LSB +: BYTE_W]),
		.job_valid      (job_valid),
		.job_res        (job_res),
		.job_take       (job_take)
	);

	// output register toward the link
	wsfe_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (job_valid),
		.in_take   (job_take),
		.in_res    (job_res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = out_res.out_byte;
	assign m_axis_tuser = {out_res.overrun, out_res.run_last, out_res.is_header};
	assign m_axis_tlast = out_res.frame_last;

endmodule

// File: bench/websocket_frame_encoder_top_tb.sv
`timescale 1ns / 1ps

module websocket_frame_encoder_top_tb;
	import wsfe_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned PHASE_ITEMS  = 38;
	localparam int unsigned NUM_PHASES   = 6;

	// kinds of rows in the directed table
	typedef enum logic [1:0] {
		ROW_START,
		ROW_BYTE,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [OPC_W-1:0]  opc;
		logic [LEN_W-1:0]  len;
		logic [KEY_W-1:0]  key;
		logic [BYTE_W-1:0] data;
		bit                typed;
		res_t              want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic                cfg_data = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic                s_axis_tuser = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [BYTE_W-1:0]   m_axis_tdata;
	logic [2:0]          m_axis_tuser;
	logic                m_axis_tlast;

	// predicted framer state
	logic              mask_en = 1'b0;
	logic [KEY_W-1:0]  frame_key = '0;
	logic [1:0]        frame_phase = '0;
	logic [LEN_W-1:0]  frame_left = '0;
	logic              frame_masked = 1'b0;

	res_t        wire_q[$];
	res_t        wire_want;
	dir_row_t    dir_rows[$];
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned src_gap_pct = 0;
	int unsigned snk_gap_pct = 0;
	bit          stall_hold = 1'b0;

	websocket_frame_encoder_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	// wire bytes expected for one accepted item
	function automatic void encode_item(input logic req, input logic [OPC_W-1:0] opc,
			input logic [LEN_W-1:0] len, input logic [KEY_W-1:0] key,
			input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] hdr[$];
		res_t              r;
		if (req == REQ_START) begin
			hdr.push_back(FIN_BIT | {4'b0000, opc});
			if (len < LEN7_LIMIT) begin
				hdr.push_back({mask_en, len[6:0]});
			end else if (len[LEN_W-1:16] == '0) begin
				hdr.push_back({mask_en, LEN16_CODE});
				hdr.push_back(len[15:8]);
				hdr.push_back(len[7:0]);
			end else begin
				hdr.push_back({mask_en, LEN64_CODE});
				for (int i = 7; i >= 0; i--) hdr.push_back(len[8*i +: 8]);
			end
			if (mask_en) begin
				for (int i = 3; i >= 0; i--) hdr.push_back(key[8*i +: 8]);
			end
			frame_key    = key;
			frame_phase  = '0;
			frame_left   = len;
			frame_masked = mask_en;
			foreach (hdr[i]) begin
				r.out_byte   = hdr[i];
				r.is_header  = 1'b1;
				r.run_last   = (i == hdr.size() - 1);
				r.frame_last = r.run_last && (len == '0);
				r.overrun    = 1'b0;
				wire_q.push_back(r);
			end
		end else begin
			r.out_byte   = data;
			r.is_header  = 1'b0;
			r.run_last   = 1'b1;
			r.frame_last = 1'b0;
			r.overrun    = 1'b0;
			if (frame_left == '0) begin
				// beyond the declared length: raw byte, state untouched
				r.overrun = 1'b1;
			end else begin
				if (frame_masked) begin
					r.out_byte = data ^ frame_key[8*(3 - int'(frame_phase)) +: 8];
				end
				frame_phase  = frame_phase + 2'd1;
				frame_left   = frame_left - 64'd1;
				r.frame_last = (frame_left == '0);
			end
			wire_q.push_back(r);
		end
	endfunction

	// offer one item and wait for its transfer
	task automatic send_item(input logic req, input logic [OPC_W-1:0] opc,
			input logic [LEN_W-1:0] len, input logic [KEY_W-1:0] key,
			input logic [BYTE_W-1:0] data, input bit typed = 1'b0,
			input res_t want = '0);
		if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {{(S_DATA_W - DATA_LSB - BYTE_W){1'b0}}, data, key, len, opc};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (typed) begin
			wire_q.push_back(want);
		end else begin
			encode_item(req, opc, len, key, data);
		end
	endtask

	// idle the input, drain the output, then write the mask register
	task automatic write_mask(input logic value);
		s_axis_tvalid <= 1'b0;
		while (wire_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		mask_en  = value;
	endtask

	// start item plus a number of payload bytes with random filler
	task automatic send_frame(input logic [LEN_W-1:0] len, input int unsigned nbytes);
		send_item(REQ_START, 4'($urandom_range(0, 15)), len, $urandom,
			8'($urandom_range(0, 255)));
		repeat (nbytes) begin
			send_item(REQ_PAYLOAD, 4'($urandom_range(0, 15)), {$urandom, $urandom},
				$urandom, 8'($urandom_range(0, 255)));
		end
	endtask

	// mostly well-formed frames, some cut short, some overrun, some stray bytes
	task automatic random_frame(inout int unsigned sent);
		int unsigned      pick;
		int unsigned      nbytes;
		logic [LEN_W-1:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			send_item(REQ_PAYLOAD, 4'($urandom_range(0, 15)), {$urandom, $urandom},
				$urandom, 8'($urandom_range(0, 255)));
			sent += 1;
		end else begin
			if (pick < 70) len = 64'($urandom_range(0, 12));
			else if (pick < 78) len = 64'($urandom_range(13, 60));
			else if (pick < 81) len = 64'($urandom_range(61, 125));
			else if (pick < 85) len = 64'($urandom_range(126, 135));
			else if (pick < 92) len = 64'($urandom_range(136, 65535));
			else len = {$urandom, $urandom};
			nbytes = (len <= 135) ? 32'(len) : $urandom_range(0, 6);
			pick = $urandom_range(0, 99);
			if (pick < 8) nbytes = $urandom_range(0, nbytes);
			else if (pick < 18) nbytes += $urandom_range(1, 3);
			send_frame(len, nbytes);
			sent += 1 + nbytes;
		end
	endtask

	function automatic void add_row(input row_kind_t kind, input logic [OPC_W-1:0] opc,
			input logic [LEN_W-1:0] len, input logic [KEY_W-1:0] key,
			input logic [BYTE_W-1:0] data, input bit typed = 1'b0, input res_t want = '0);
		dir_row_t r;
		r.kind  = kind;
		r.opc   = opc;
		r.len   = len;
		r.key   = key;
		r.data  = data;
		r.typed = typed;
		r.want  = want;
		dir_rows.push_back(r);
	endfunction

	// receiver: random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (stall_hold) begin
				m_axis_tready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
				stall_hold = 1'b0;
			end else if (snk_gap_pct != 0 && $urandom_range(0, 99) < snk_gap_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// output check against the oldest expected byte
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (wire_q.size() == 0) begin
				report_mismatch("unexpected transfer, out_byte", 64'(m_axis_tdata), '0);
			end else begin
				wire_want = wire_q.pop_front();
				if (m_axis_tdata !== wire_want.out_byte)
					report_mismatch("out_byte", 64'(m_axis_tdata),
						64'(wire_want.out_byte));
				if (m_axis_tuser[0] !== wire_want.is_header)
					report_mismatch("is_header", 64'(m_axis_tuser[0]),
						64'(wire_want.is_header));
				if (m_axis_tuser[1] !== wire_want.run_last)
					report_mismatch("run_last", 64'(m_axis_tuser[1]),
						64'(wire_want.run_last));
				if (m_axis_tuser[2] !== wire_want.overrun)
					report_mismatch("overrun", 64'(m_axis_tuser[2]),
						64'(wire_want.overrun));
				if (m_axis_tlast !== wire_want.frame_last)
					report_mismatch("frame_last", 64'(m_axis_tlast),
						64'(wire_want.frame_last));
			end
		end
	end

	// stimulus
	initial begin
		logic        phase_mask[NUM_PHASES];
		int unsigned sent;

		// directed: stray byte, empty frame, length forms and edges, masking
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'hA5, 1'b1, {8'hA5, 1'b0, 1'b1, 1'b0, 1'b1});
		add_row(ROW_START, 4'h0, 64'd0, 32'h0, 8'h00);
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'h00, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0, 1'b1});
		add_row(ROW_START, 4'hF, 64'd125, 32'hFFFF_FFFF, 8'hFF);
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'hFF);
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'h00);
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'h5A);
		add_row(ROW_START, 4'h1, 64'd126, 32'h0, 8'h00);
		add_row(ROW_START, 4'h2, 64'd65535, 32'h0, 8'h00);
		add_row(ROW_START, 4'h8, 64'd65536, 32'h0, 8'h00);
		add_row(ROW_START, 4'h9, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 8'h00);
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'h3C);
		add_row(ROW_CFG, 4'h0, 64'd0, 32'h0, 8'h01);
		add_row(ROW_START, 4'hA, 64'd3, 32'h0102_0304, 8'h00);
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'h11);
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'h22);
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'h33);
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'h44, 1'b1, {8'h44, 1'b0, 1'b1, 1'b0, 1'b1});
		add_row(ROW_START, 4'h0, 64'd0, 32'hDEAD_BEEF, 8'h00);
		add_row(ROW_START, 4'h2, 64'd300, 32'h8000_0001, 8'h00);
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'hFF);
		add_row(ROW_BYTE, 4'h0, 64'd0, 32'h0, 8'h00);
		add_row(ROW_START, 4'hF, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 8'h00);
		add_row(ROW_CFG, 4'h0, 64'd0, 32'h0, 8'h00);

		phase_mask = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

		// reset
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		src_gap_pct = 20;
		snk_gap_pct = 20;
		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CFG: begin
					write_mask(dir_rows[i].data[0]);
				end
				ROW_START: begin
					send_item(REQ_START, dir_rows[i].opc, dir_rows[i].len, dir_rows[i].key,
						dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
				end
				default: begin
					send_item(REQ_PAYLOAD, dir_rows[i].opc, dir_rows[i].len, dir_rows[i].key,
						dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
				end
			endcase
		end

		// random phases, each with its own mask setting and idling mix
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_mask(phase_mask[p]);
			case (p)
				0: begin src_gap_pct = 0;  snk_gap_pct = 30; end
				1: begin src_gap_pct = 15; snk_gap_pct = 0;  end
				2: begin src_gap_pct = 30; snk_gap_pct = 30; end
				3: begin src_gap_pct = 10; snk_gap_pct = 50; end
				4: begin src_gap_pct = 50; snk_gap_pct = 10; end
				default: begin src_gap_pct = 0; snk_gap_pct = 0; end
			endcase
			sent = 0;
			if (p == 1) begin
				// long receiver hold-off while a long frame keeps coming
				stall_hold = 1'b1;
				send_frame(64'd48, 48);
				sent += 49;
			end
			while (sent < PHASE_ITEMS) random_frame(sent);
		end

		// drain and finish
		s_axis_tvalid <= 1'b0;
		while (wire_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
